// ===== hw/rtl/slot_allocator_free_stack_defines.svh =====
// ----------------------------------------------------------------------------
// Slot allocator defines
// Assertion macros shared by the slot allocator RTL.
// ----------------------------------------------------------------------------
`ifndef SLOT_ALLOCATOR_FREE_STACK_DEFINES_SVH
`define SLOT_ALLOCATOR_FREE_STACK_DEFINES_SVH

// Condition implies consequence in the same cycle.
`define SAS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("slot allocator: same-cycle check failed");

// Condition implies consequence in the next cycle.
`define SAS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("slot allocator: next-cycle check failed");

`endif

// ===== hw/rtl/sas_pkg.sv =====
// ----------------------------------------------------------------------------
// Slot allocator package
// Widths, status codes, command codes and register indexes.
// ----------------------------------------------------------------------------
package sas_pkg;

    localparam int MAX_SLOTS = 1024;
    localparam int SLOT_W    = $clog2(MAX_SLOTS);
    localparam int CNT_W     = 11;
    localparam int HANDLE_W  = 64;
    localparam int STATUS_W  = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 64;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_READY = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NULL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_REJECT    = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd5;

    // Commands
    localparam logic CMD_ACQUIRE = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE   = 2'd2;

    // Saturation limit of the use counter
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

endpackage

// ===== hw/rtl/sas_stack_ram.sv =====
// ----------------------------------------------------------------------------
// Free stack RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module sas_stack_ram
    import sas_pkg::*;
(
    input  logic              clk,
    input  logic              we,
    input  logic [SLOT_W-1:0] waddr,
    input  logic [SLOT_W-1:0] wdata,
    input  logic [SLOT_W-1:0] raddr,
    output logic [SLOT_W-1:0] rdata
);

    logic [SLOT_W-1:0] mem [MAX_SLOTS];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, registered read data
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/slot_allocator_free_stack.sv =====
// ----------------------------------------------------------------------------
// Slot allocator with free stack
// Grants and frees slots of a descriptor table; freed slots are reused LIFO.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter on start/cmd/handle/slot and are taken when start is high
//   and busy is low. Each item gives exactly one result, shown for one cycle
//   with done high; the receiver must take it then, it cannot stall.
//   Timing: an accepted item is latched, evaluated in the EXEC state, and its
//   result is registered onto the ports. busy is high for one cycle, so no new
//   item is taken while one is in EXEC. The EXEC state covers the registered
//   read of the free-stack top from the stack RAM.
//   Configuration goes through cfg_we/cfg_index/cfg_data while idle: capacity,
//   default handle, and enable (1 initializes if both are nonzero, 0 shuts
//   down). Unknown indexes are ignored.
//   Reset: registers clear, the allocator is not ready, next slot is 1. The
//   stack RAM is not cleared; only entries below the fill count are used.
// ----------------------------------------------------------------------------
`include "slot_allocator_free_stack_defines.svh"

module slot_allocator_free_stack
    import sas_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // command channel
    input  logic                 start,
    output logic                 busy,
    input  logic                 cmd,
    input  logic [HANDLE_W-1:0]  handle,
    input  logic [SLOT_W-1:0]    slot,
    // result channel
    output logic                 done,
    output logic [STATUS_W-1:0]  status,
    output logic [SLOT_W-1:0]    granted_slot,
    output logic                 write_valid,
    output logic [SLOT_W-1:0]    write_slot,
    output logic [HANDLE_W-1:0]  write_handle,
    output logic [CNT_W-1:0]     used_count,
    output logic                 first_exhaustion,
    // configuration
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t              state_reg;
    logic [CNT_W-1:0]    capacity_reg;
    logic [HANDLE_W-1:0] default_reg;
    logic [SLOT_W-1:0]   depth_reg, depth_next;
    logic [CNT_W-1:0]    next_slot_reg, next_slot_next;
    logic [CNT_W-1:0]    in_use_reg, in_use_next;
    logic                ready_reg;
    logic                seen_reg, seen_next;

    // latched item
    logic                cmd_reg;
    logic [HANDLE_W-1:0] handle_reg;
    logic [SLOT_W-1:0]   slot_reg;

    // registered result
    logic                done_reg;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [SLOT_W-1:0]   granted_reg, granted_next;
    logic                wvalid_reg, wvalid_next;
    logic [SLOT_W-1:0]   wslot_reg, wslot_next;
    logic [HANDLE_W-1:0] whandle_reg, whandle_next;
    logic                first_reg, first_next;

    logic [CNT_W-1:0]    eff_cap;
    logic [SLOT_W-1:0]   top_slot;
    logic                push;
    logic                accept;

    assign accept  = start && (state_reg == S_IDLE);
    assign eff_cap = (capacity_reg > CNT_W'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS) : capacity_reg;

    // free stack storage; top entry is read while idle
    sas_stack_ram u_stack (
        .clk   (clk),
        .we    (push && (state_reg == S_EXEC)),
        .waddr (depth_reg),
        .wdata (slot_reg),
        .raddr (depth_reg - 1'b1),
        .rdata (top_slot)
    );

    // command evaluation
    always_comb
    begin
        status_next    = ST_OK;
        granted_next   = '0;
        wvalid_next    = 1'b0;
        wslot_next     = '0;
        whandle_next   = '0;
        first_next     = 1'b0;
        depth_next     = depth_reg;
        next_slot_next = next_slot_reg;
        in_use_next    = in_use_reg;
        seen_next      = seen_reg;
        push           = 1'b0;
        if (!ready_reg)
        begin
            status_next = ST_NOT_READY;
        end
        else if (cmd_reg == CMD_ACQUIRE)
        begin
            if (handle_reg == '0)
            begin
                status_next = ST_NULL;
            end
            else if (depth_reg != '0 || next_slot_reg < eff_cap)
            begin
                if (depth_reg != '0)
                begin
                    depth_next = depth_reg - 1'b1;
                    granted_next = top_slot;
                end
                else
                begin
                    next_slot_next = next_slot_reg + 1'b1;
                    granted_next = next_slot_reg[SLOT_W-1:0];
                end
                wvalid_next  = 1'b1;
                wslot_next   = granted_next;
                whandle_next = handle_reg;
                if (in_use_reg != CNT_MAX)
                begin
                    in_use_next = in_use_reg + 1'b1;
                end
            end
            else
            begin
                status_next = ST_EXHAUSTED;
                first_next  = !seen_reg;
                seen_next   = 1'b1;
            end
        end
        else
        begin
            if (slot_reg == '0 || {1'b0, slot_reg} >= eff_cap)
            begin
                status_next = ST_REJECT;
            end
            else if (({1'b0, depth_reg} + 1'b1) >= eff_cap)
            begin
                status_next = ST_FULL;
            end
            else
            begin
                push         = 1'b1;
                wvalid_next  = 1'b1;
                wslot_next   = slot_reg;
                whandle_next = default_reg;
                depth_next   = depth_reg + 1'b1;
                if (in_use_reg != '0)
                begin
                    in_use_next = in_use_reg - 1'b1;
                end
            end
        end
    end

    // item latch, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg    <= cmd;
            handle_reg <= handle;
            slot_reg   <= slot;
        end
    end

    // control state, configuration and registered result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            capacity_reg  <= '0;
            default_reg   <= '0;
            depth_reg     <= '0;
            next_slot_reg <= CNT_W'(1);
            in_use_reg    <= '0;
            ready_reg     <= 1'b0;
            seen_reg      <= 1'b0;
            done_reg      <= 1'b0;
            status_reg    <= ST_OK;
            granted_reg   <= '0;
            wvalid_reg    <= 1'b0;
            wslot_reg     <= '0;
            whandle_reg   <= '0;
            first_reg     <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    state_reg     <= S_IDLE;
                    done_reg      <= 1'b1;
                    status_reg    <= status_next;
                    granted_reg   <= granted_next;
                    wvalid_reg    <= wvalid_next;
                    wslot_reg     <= wslot_next;
                    whandle_reg   <= whandle_next;
                    first_reg     <= first_next;
                    depth_reg     <= depth_next;
                    next_slot_reg <= next_slot_next;
                    in_use_reg    <= in_use_next;
                    seen_reg      <= seen_next;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
            // register writes; the user must issue them only while idle, the block does not enforce it
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_CAPACITY:
                    begin
                        capacity_reg <= cfg_data[CNT_W-1:0];
                    end
                    CFG_DEFAULT:
                    begin
                        default_reg <= cfg_data[HANDLE_W-1:0];
                    end
                    CFG_ENABLE:
                    begin
                        if (cfg_data[0])
                        begin
                            if (capacity_reg != '0 && default_reg != '0)
                            begin
                                next_slot_reg <= CNT_W'(1);
                                depth_reg     <= '0;
                                in_use_reg    <= CNT_W'(1);
                                seen_reg      <= 1'b0;
                                ready_reg     <= 1'b1;
                            end
                        end
                        else
                        begin
                            ready_reg     <= 1'b0;
                            next_slot_reg <= CNT_W'(1);
                            depth_reg     <= '0;
                            in_use_reg    <= '0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    assign busy             = (state_reg == S_EXEC);
    assign done             = done_reg;
    assign status           = status_reg;
    assign granted_slot     = granted_reg;
    assign write_valid      = wvalid_reg;
    assign write_slot       = wslot_reg;
    assign write_handle     = whandle_reg;
    assign used_count       = in_use_reg;
    assign first_exhaustion = first_reg;

    // checks
    `SAS_ASSERT_NEXT(a_exec_after_accept, clk, rst_n, start && !busy, busy && !done)
    `SAS_ASSERT_NEXT(a_done_after_exec, clk, rst_n, busy, done && !busy)
    `SAS_ASSERT_NOW(a_grant_only_ok, clk, rst_n, done && status != ST_OK, granted_slot == '0)
    `SAS_ASSERT_NOW(a_next_bound, clk, rst_n, ready_reg, next_slot_reg <= CNT_W'(MAX_SLOTS))

endmodule

// ===== tb/slot_allocator_free_stack_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Slot allocator testbench
// Sends acquire and release commands with random idle gaps and compares each
// result field with a behavioral copy of the allocator kept in this module.
// Directed tests cover not-ready, exhaustion, rejected and full-stack releases
// and register corners; random phases sweep capacities and re-enables.
// ----------------------------------------------------------------------------
module slot_allocator_free_stack_tb;
    import sas_pkg::*;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   granted;
        logic                wvalid;
        logic [SLOT_W-1:0]   wslot;
        logic [HANDLE_W-1:0] whandle;
        logic [CNT_W-1:0]    used;
        logic                first;
    } alloc_resp_t;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic                 cmd;
    logic [HANDLE_W-1:0]  handle;
    logic [SLOT_W-1:0]    slot;
    logic                 done;
    logic [STATUS_W-1:0]  status;
    logic [SLOT_W-1:0]    granted_slot;
    logic                 write_valid;
    logic [SLOT_W-1:0]    write_slot;
    logic [HANDLE_W-1:0]  write_handle;
    logic [CNT_W-1:0]     used_count;
    logic                 first_exhaustion;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    // Allocator mirror
    logic [CNT_W-1:0]    cap_reg;
    logic [HANDLE_W-1:0] dflt_reg;
    logic [SLOT_W-1:0]   free_slots [MAX_SLOTS];
    int                  free_cnt;
    int                  bump_ptr;
    logic [CNT_W-1:0]    slots_used;
    bit                  alloc_ready;
    bit                  exhaust_flag;
    logic [SLOT_W-1:0]   held [$];        // granted, not yet released
    alloc_resp_t         alloc_responses [$];

    int err_cnt;
    bit steady;                           // no idle gaps while set

    slot_allocator_free_stack u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .cmd              (cmd),
        .handle           (handle),
        .slot             (slot),
        .done             (done),
        .status           (status),
        .granted_slot     (granted_slot),
        .write_valid      (write_valid),
        .write_slot       (write_slot),
        .write_handle     (write_handle),
        .used_count       (used_count),
        .first_exhaustion (first_exhaustion),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic int eff_cap();
        return (cap_reg > MAX_SLOTS) ? MAX_SLOTS : int'(cap_reg);
    endfunction

    // Register write side effects
    function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [CFG_W-1:0] data);
        case (idx)
            CFG_CAPACITY: cap_reg = data[CNT_W-1:0];
            CFG_DEFAULT:  dflt_reg = data;
            CFG_ENABLE:
            begin
                if (data[0])
                begin
                    // only a complete setup initializes
                    if (cap_reg != '0 && dflt_reg != '0)
                    begin
                        bump_ptr     = 1;
                        free_cnt     = 0;
                        slots_used   = 1;
                        exhaust_flag = 1'b0;
                        alloc_ready  = 1'b1;
                        held.delete();
                    end
                end
                else
                begin
                    alloc_ready = 1'b0;
                    bump_ptr    = 1;
                    free_cnt    = 0;
                    slots_used  = '0;
                    held.delete();
                end
            end
            default: ;
        endcase
    endfunction

    // Allocator response for one accepted item; updates the mirror
    function automatic void allocate_step(input logic c, input logic [HANDLE_W-1:0] h,
                                          input logic [SLOT_W-1:0] s);
        alloc_resp_t r;
        int          cap;
        bit          found;
        r   = '0;
        cap = eff_cap();
        if (!alloc_ready)
            r.status = ST_NOT_READY;
        else if (c == CMD_ACQUIRE)
        begin
            if (h == '0)
                r.status = ST_NULL;
            else if (free_cnt > 0 || bump_ptr < cap)
            begin
                // stack first, then bump pointer
                if (free_cnt > 0)
                begin
                    free_cnt--;
                    r.granted = free_slots[free_cnt];
                end
                else
                begin
                    r.granted = bump_ptr[SLOT_W-1:0];
                    bump_ptr++;
                end
                r.status  = ST_OK;
                r.wvalid  = 1'b1;
                r.wslot   = r.granted;
                r.whandle = h;
                if (slots_used != CNT_MAX)
                    slots_used++;
                held.insert(held.size(), r.granted);
            end
            else
            begin
                r.status     = ST_EXHAUSTED;
                r.first      = !exhaust_flag;
                exhaust_flag = 1'b1;
            end
        end
        else
        begin
            if (s == '0 || s >= cap)
                r.status = ST_REJECT;
            else if (free_cnt + 1 >= cap)
                r.status = ST_FULL;
            else
            begin
                r.status  = ST_OK;
                r.wvalid  = 1'b1;
                r.wslot   = s;
                r.whandle = dflt_reg;
                free_slots[free_cnt] = s;
                free_cnt++;
                if (slots_used != '0)
                    slots_used--;
                found = 1'b0;
                for (int i = 0; i < held.size() && !found; i++)
                begin
                    if (held[i] == s)
                    begin
                        held.delete(i);
                        found = 1'b1;
                    end
                end
            end
        end
        r.used = slots_used;
        alloc_responses.insert(alloc_responses.size(), r);
    endfunction

    function automatic void compare_field(input string name, input logic [63:0] want,
                                          input logic [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            err_cnt++;
        end
    endfunction

    // Result checker: the receiver takes every done cycle
    always @(posedge clk)
    begin : result_check
        alloc_resp_t want;
        if (rst_n && done)
        begin
            if (alloc_responses.size() == 0)
            begin
                $error("result with no item outstanding, status %0d", status);
                err_cnt++;
            end
            else
            begin
                want = alloc_responses.pop_front();
                compare_field("status", 64'(want.status), 64'(status));
                compare_field("granted_slot", 64'(want.granted), 64'(granted_slot));
                compare_field("write_valid", 64'(want.wvalid), 64'(write_valid));
                compare_field("write_slot", 64'(want.wslot), 64'(write_slot));
                compare_field("write_handle", want.whandle, write_handle);
                compare_field("used_count", 64'(want.used), 64'(used_count));
                compare_field("first_exhaustion", 64'(want.first), 64'(first_exhaustion));
            end
        end
    end

    // One item; start stays high afterwards unless the next item idles first
    task automatic send_item(input logic c, input logic [HANDLE_W-1:0] h,
                             input logic [SLOT_W-1:0] s);
        int gap;
        gap = 0;
        if (!steady && $urandom_range(99) < 11)
            gap = $urandom_range(5, 1);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start  <= 1'b1;
        cmd    <= c;
        handle <= h;
        slot   <= s;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        allocate_step(c, h, s);
    endtask

    // Stop sending and let every outstanding result come back
    task automatic wait_drained;
        int waited;
        waited = 0;
        start <= 1'b0;
        while (alloc_responses.size() != 0 && waited < 50)
        begin
            @(posedge clk);
            waited++;
        end
        if (alloc_responses.size() != 0)
        begin
            $error("%0d results never arrived", alloc_responses.size());
            err_cnt++;
            alloc_responses.delete();
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        apply_register(idx, data);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [HANDLE_W-1:0] random_handle();
        if ($urandom_range(99) < 5)
            return '0;
        return {$urandom, $urandom};
    endfunction

    // Mostly slots that are held, some boundary and wild indexes
    function automatic logic [SLOT_W-1:0] release_slot();
        int pick;
        pick = $urandom_range(99);
        if (pick < 70 && held.size() > 0)
            return held[$urandom_range(held.size() - 1)];
        if (pick < 85)
            return SLOT_W'($urandom_range(eff_cap()));
        return SLOT_W'($urandom);
    endfunction

    task automatic random_item(input int acq_pct);
        if ($urandom_range(99) < acq_pct)
            send_item(CMD_ACQUIRE, random_handle(), SLOT_W'($urandom));
        else
            send_item(CMD_RELEASE, {$urandom, $urandom}, release_slot());
    endtask

    // Commands before any setup, and an incomplete enable
    task automatic test_not_ready;
        send_item(CMD_ACQUIRE, 64'h1234_5678_9abc_def0, '0);
        send_item(CMD_RELEASE, '0, 10'd1);
        wait_drained();
        write_cfg(CFG_ENABLE, 64'd1);
        send_item(CMD_ACQUIRE, '1, '1);
        wait_drained();
    endtask

    // Four-slot table: grants, exhaustion, rejects, full stack, LIFO reuse
    task automatic test_small_table;
        write_cfg(CFG_CAPACITY, 64'd4);
        write_cfg(CFG_DEFAULT, {$urandom, $urandom} | 64'h1);
        write_cfg(CFG_ENABLE, 64'd1);
        send_item(CMD_ACQUIRE, '1, '0);
        send_item(CMD_ACQUIRE, 64'h1, '1);
        send_item(CMD_ACQUIRE, {$urandom, $urandom} | 64'h1, '0);
        send_item(CMD_ACQUIRE, 64'h8000_0000_0000_0000, '0);
        send_item(CMD_ACQUIRE, 64'h55, '0);
        send_item(CMD_ACQUIRE, '0, '0);
        send_item(CMD_RELEASE, '1, 10'd0);
        send_item(CMD_RELEASE, '0, 10'd4);
        send_item(CMD_RELEASE, '0, '1);
        send_item(CMD_RELEASE, '0, 10'd3);
        send_item(CMD_RELEASE, '0, 10'd1);
        send_item(CMD_RELEASE, '0, 10'd2);
        send_item(CMD_RELEASE, '0, 10'd2);
        send_item(CMD_ACQUIRE, 64'h77, '0);
        wait_drained();
    endtask

    // Zero capacity while ready, oversized capacity, shutdown with upper bits
    task automatic test_config_corners;
        write_cfg(CFG_CAPACITY, 64'd0);
        write_cfg(CFG_ENABLE, 64'd1);
        send_item(CMD_ACQUIRE, 64'h99, '0);
        send_item(CMD_RELEASE, '0, 10'd1);
        wait_drained();
        write_cfg(CFG_CAPACITY, 64'd2047);
        write_cfg(CFG_ENABLE, 64'd1);
        send_item(CMD_ACQUIRE, 64'habc, '0);
        send_item(CMD_RELEASE, '0, '1);
        send_item(CMD_ACQUIRE, 64'hdef, '0);
        wait_drained();
        write_cfg(CFG_ENABLE, 64'hFFFF_FFFF_FFFF_FFFE);
        send_item(CMD_ACQUIRE, 64'h1, '0);
        wait_drained();
    endtask

    // Phases over many capacities: re-enable, shutdown, live capacity change
    task automatic test_random_phases;
        int                  caps [14] = '{2, 3, 5, 8, 1, 17, 64, 2047, 6, 1024, 33, 4, 1025, 12};
        logic [HANDLE_W-1:0] dflt;
        logic [CFG_W-1:0]    cap_word;
        int                  acq_pct;
        for (int i = 0; i < 14; i++)
        begin
            wait_drained();
            dflt = (i % 7 == 3) ? '1 : {$urandom, $urandom};
            if (dflt == '0)
                dflt = 64'h1;
            // odd phases carry junk above the capacity field
            cap_word = 64'(caps[i]);
            if (i % 2 == 1)
                cap_word = ({$urandom, $urandom} & ~64'h7FF) | cap_word;
            if (i % 4 == 1)
                write_cfg(CFG_ENABLE, '0);
            write_cfg(CFG_CAPACITY, cap_word);
            if (i % 4 != 2)
            begin
                write_cfg(CFG_DEFAULT, dflt);
                write_cfg(CFG_ENABLE, 64'd1);
            end
            steady  = (i == 5 || i == 6);
            acq_pct = $urandom_range(75, 35);
            repeat (100) random_item(acq_pct);
        end
        steady = 1'b0;
        wait_drained();
    endtask

    // Main sequence
    initial
    begin
        err_cnt      = 0;
        steady       = 1'b0;
        cap_reg      = '0;
        dflt_reg     = '0;
        free_cnt     = 0;
        bump_ptr     = 1;
        slots_used   = '0;
        alloc_ready  = 1'b0;
        exhaust_flag = 1'b0;
        rst_n     <= 1'b0;
        start     <= 1'b0;
        cmd       <= CMD_ACQUIRE;
        handle    <= '0;
        slot      <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_CAPACITY;
        cfg_data  <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_not_ready();
        test_small_table();
        test_config_corners();
        test_random_phases();

        if (err_cnt == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
